@@ sv/sito_pkg.sv @@
// Shared constants and types for the strided index to offset pipeline.
// No dependencies; every other file imports this package.
package sito_pkg;

  localparam int IDX_W        = 32;  // element index width
  localparam int SIZE_W       = 16;  // dimension extent width
  localparam int STRIDE_W     = 32;  // dimension stride width
  localparam int OFF_W        = 50;  // storage offset width
  localparam int PROD_W       = SIZE_W + STRIDE_W;
  localparam int NUM_AXES     = 4;
  localparam int DIMS_DEFAULT = 4;

  // Divider pipeline: quotient bits retired per stage and stages per dimension
  localparam int DIV_BITS     = 4;
  localparam int DIV_STAGES   = IDX_W / DIV_BITS;

  // Configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int AXIS_W       = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_BASE = 3'd4;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [STRIDE_W-1:0] stride_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [OFF_W-1:0]    off_t;
  typedef logic [PROD_W-1:0]   prod_t;

endpackage

@@ sv/sito_ifs.sv @@
// Handshake channel interfaces for index requests and offset results.
// Depends on sito_pkg for payload types.
interface sito_index_if import sito_pkg::*; ();
  logic valid;
  logic ready;
  idx_t element_index;
  modport source (output valid, output element_index, input ready);
  modport sink   (input valid, input element_index, output ready);
endinterface

interface sito_offset_if import sito_pkg::*; ();
  logic valid;
  logic ready;
  off_t storage_offset;
  modport source (output valid, output storage_offset, input ready);
  modport sink   (input valid, input storage_offset, output ready);
endinterface

@@ sv/strided_index_to_offset.sv @@
// Strided index to offset pipeline: top level with config registers.
// One request per cycle sustained while the result output is not stalled.
// The depth is set by the per-dimension 32-bit divider, 4 quotient bits a stage.
// Synchronous active-low reset clears all valid bits and loads sizes of one,
// inner stride one and other strides zero. Depends on sito_pkg, sito_ifs.
module strided_index_to_offset import sito_pkg::*; #(
  parameter int DIMS = DIMS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sito_index_if.sink            in_req,
  sito_offset_if.source         out_res
);

  localparam int NS = DIMS * DIV_STAGES;

  // Configuration registers
  size_t   size_r   [NUM_AXES];
  stride_t stride_r [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        size_r[a]   <= size_t'(1);
        stride_r[a] <= '0;
      end
      stride_r[0] <= stride_t'(1);
    end else if (cfg_we) begin
      if (cfg_index < CFG_STRIDE_BASE) begin
        size_r[cfg_index[AXIS_W-1:0]] <= cfg_wdata[SIZE_W-1:0];
      end else begin
        stride_r[cfg_index[AXIS_W-1:0]] <= cfg_wdata[STRIDE_W-1:0];
      end
    end
  end

  // Zero extent divides as one
  size_t divisor [NUM_AXES];
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      divisor[a] = (size_r[a] == '0) ? size_t'(1) : size_r[a];
    end
  end

  // Whole pipe advances together; hold everything while the result waits
  logic adv;
  logic fin_vld_r;
  assign adv          = !fin_vld_r || out_res.ready;
  assign in_req.ready = adv;

  // Divider stages: quotient passes outward, remainder becomes the digit
  logic                         div_vld_r [NS];
  idx_t                         quo_r     [NS];
  size_t                        rem_r     [NS];
  logic [DIMS-1:0][SIZE_W-1:0]  dig_r     [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_div
      localparam int D = k / DIV_STAGES;
      logic                        vld_in;
      idx_t                        quo_in;
      size_t                       rem_in;
      logic [DIMS-1:0][SIZE_W-1:0] dig_in;
      idx_t                        quo_nxt;
      size_t                       rem_nxt;
      logic [DIMS-1:0][SIZE_W-1:0] dig_nxt;

      if (k == 0) begin : g_first
        assign vld_in = in_req.valid;
        assign quo_in = in_req.element_index;
        assign dig_in = '0;
      end else begin : g_next
        assign vld_in = div_vld_r[k-1];
        assign quo_in = quo_r[k-1];
        assign dig_in = dig_r[k-1];
      end

      // Restart the remainder at each new dimension
      if (k % DIV_STAGES == 0) begin : g_rst_rem
        assign rem_in = '0;
      end else begin : g_keep_rem
        assign rem_in = rem_r[k-1];
      end

      sito_div_step u_step (
        .quo_i     (quo_in),
        .rem_i     (rem_in),
        .divisor_i (divisor[D]),
        .quo_o     (quo_nxt),
        .rem_o     (rem_nxt)
      );

      always_comb begin
        dig_nxt    = dig_in;
        dig_nxt[D] = rem_nxt;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          div_vld_r[k] <= 1'b0;
        end else if (adv) begin
          div_vld_r[k] <= vld_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          quo_r[k] <= quo_nxt;
          rem_r[k] <= rem_nxt;
          dig_r[k] <= dig_nxt;
        end
      end
    end
  endgenerate

  // Digit times stride, one product per dimension
  logic  mul_vld_r;
  prod_t prod_r [DIMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (adv) begin
      mul_vld_r <= div_vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < DIMS; d++) begin
        prod_r[d] <= PROD_W'(dig_r[NS-1][d]) * PROD_W'(stride_r[d]);
      end
    end
  end

  // Pad absent dimensions with zero for the fixed adder tree
  prod_t prod_pad [NUM_AXES];
  genvar p;
  generate
    for (p = 0; p < NUM_AXES; p++) begin : g_pad
      if (p < DIMS) begin : g_used
        assign prod_pad[p] = prod_r[p];
      end else begin : g_zero
        assign prod_pad[p] = '0;
      end
    end
  endgenerate

  // Pairwise sums
  logic                pair_vld_r;
  logic [PROD_W:0]     pair_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
    end else if (adv) begin
      pair_vld_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_r[0] <= {1'b0, prod_pad[0]} + {1'b0, prod_pad[1]};
      pair_r[1] <= {1'b0, prod_pad[2]} + {1'b0, prod_pad[3]};
    end
  end

  // Final sum, doubles as the output register
  off_t fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (adv) begin
      fin_vld_r <= pair_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r <= OFF_W'(pair_r[0]) + OFF_W'(pair_r[1]);
    end
  end

  assign out_res.valid          = fin_vld_r;
  assign out_res.storage_offset = fin_r;

endmodule

@@ sv/sito_div_step.sv @@
// Restoring division slice: retires DIV_BITS quotient bits per pass.
// Depends on sito_pkg.
module sito_div_step import sito_pkg::*; (
  input  idx_t  quo_i,
  input  size_t rem_i,
  input  size_t divisor_i,
  output idx_t  quo_o,
  output size_t rem_o
);

  always_comb begin
    logic [SIZE_W:0] part;
    idx_t            q;
    size_t           rem;
    rem = rem_i;
    q   = quo_i;
    for (int b = 0; b < DIV_BITS; b++) begin
      part = {rem, q[IDX_W-1]};
      q    = {q[IDX_W-2:0], 1'b0};
      if (part >= {1'b0, divisor_i}) begin
        part = part - {1'b0, divisor_i};
        q[0] = 1'b1;
      end
      rem = part[SIZE_W-1:0];
    end
    quo_o = q;
    rem_o = rem;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the strided index to offset pipeline: directed and random index
// requests checked against an in-bench offset predictor. Depends on sito_pkg and sito_ifs.
`timescale 1ns / 100ps
module tb_top import sito_pkg::*;;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_INNER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_THIRD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_OUTER    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_INNER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_THIRD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_OUTER  = 3'd7;
  localparam int PIPE_DEPTH = 4 * 8 + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sito_index_if  in_req();
  sito_offset_if out_res();

  strided_index_to_offset uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_req(in_req.sink), .out_res(out_res.source)
  );

  // Shadow copy of the view registers, inner dimension first
  size_t   dim_extent [NUM_AXES];
  stride_t dim_step   [NUM_AXES];

  off_t offset_queue[$];
  int   fail_count = 0;
  int   cycle_count = 0;

  initial begin
    in_req.valid = 1'b0;
    in_req.element_index = '0;
    out_res.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mixed-radix split of the index; zero extents act as one, the leftover
  // quotient past the outer dimension is dropped so the outer digit wraps.
  function automatic off_t predict_offset(idx_t index);
    logic [63:0] rest;
    logic [63:0] radix;
    logic [63:0] total;
    rest = 64'(index);
    total = '0;
    for (int d = 0; d < NUM_AXES; d++) begin
      radix = (dim_extent[d] == '0) ? 64'd1 : 64'(dim_extent[d]);
      total += (rest % radix) * 64'(dim_step[d]);
      rest = rest / radix;
    end
    return off_t'(total);
  endfunction

  // Write one register and leave the enable high; caller guarantees the
  // pipeline is empty and drops the enable after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx < CFG_STRIDE_BASE) dim_extent[idx[AXIS_W-1:0]] = value[SIZE_W-1:0];
    else dim_step[idx[AXIS_W-1:0]] = value;
  endtask

  task automatic set_view(size_t s0, size_t s1, size_t s2, size_t s3,
                          stride_t t0, stride_t t1, stride_t t2, stride_t t3);
    write_reg(REG_SIZE_INNER, 32'(s0));
    write_reg(REG_SIZE_SECOND, 32'(s1));
    write_reg(REG_SIZE_THIRD, 32'(s2));
    write_reg(REG_SIZE_OUTER, 32'(s3));
    write_reg(REG_STRIDE_INNER, t0);
    write_reg(REG_STRIDE_SECOND, t1);
    write_reg(REG_STRIDE_THIRD, t2);
    write_reg(REG_STRIDE_OUTER, t3);
    cfg_we <= 1'b0;
  endtask

  // Burst/gap sender state
  int burst_left = 0;

  // Send one request; valid stays high across a burst, drops in gaps
  task automatic send_index(idx_t index);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_req.valid <= 1'b1;
    in_req.element_index <= index;
    offset_queue.push_back(predict_offset(index));
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Hold the sender until every expected offset has come, then flush extra cycles
  task automatic drain();
    in_req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (offset_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 5) @(posedge clk);
  endtask

  // Receiver stall pattern: phases of always-ready, random and heavy stall
  always @(posedge clk) begin
    int phase;
    phase = (cycle_count / 300) % 3;
    if (!rst_n) out_res.ready <= 1'b0;
    else if (phase == 0) out_res.ready <= 1'b1;
    else if (phase == 1) out_res.ready <= ($urandom_range(0, 3) != 0);
    else out_res.ready <= ($urandom_range(0, 4) == 0);
  end

  // Compare each accepted offset with the oldest prediction
  always @(posedge clk) begin
    off_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (offset_queue.size() == 0) begin
        $error("storage_offset: unexpected result %0h", out_res.storage_offset);
        fail_count++;
      end else begin
        want = offset_queue.pop_front();
        if (out_res.storage_offset !== want) begin
          $error("storage_offset: expected %0h actual %0h", want,
                 out_res.storage_offset);
          fail_count++;
        end
      end
    end
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic size_t rand_extent();
    case ($urandom_range(0, 5))
      0: return size_t'($urandom_range(0, 1));
      1: return 16'hFFFF;
      2: return size_t'($urandom);
      default: return size_t'($urandom_range(2, 9));
    endcase
  endfunction

  function automatic stride_t rand_step();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return stride_t'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic idx_t rand_index();
    case ($urandom_range(0, 3))
      0: return idx_t'($urandom_range(0, 2000));
      1: return 32'hFFFF_FFFF - idx_t'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // Reset values: all extents one, so every index maps to offset zero
  task automatic test_reset_view();
    send_index('0);
    send_index(32'hFFFF_FFFF);
    send_index(32'h5555_AAAA);
    drain();
  endtask

  // Extremes: full-size dims, max strides, zero sizes, broadcast, wrap
  task automatic test_directed_views();
    set_view(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_index('0);
    send_index(32'hFFFF_FFFF);
    send_index(32'hFFFE_FFFF);
    send_index(32'h0001_0000);
    drain();
    // zero extents act as one; broadcast inner dim
    set_view(16'h0000, 16'd3, 16'h0000, 16'd5, 32'd0, 32'd7, 32'd11, 32'd13);
    send_index(32'd0);
    send_index(32'd2);
    send_index(32'd3);
    send_index(32'd14);
    send_index(32'd15);
    drain();
    // small tensor, index beyond the element count wraps the outer digit
    set_view(16'd2, 16'd3, 16'd4, 16'd5, 32'd1, 32'd2, 32'd6, 32'd24);
    for (int i = 118; i < 124; i++) send_index(idx_t'(i));
    send_index(32'hFFFF_FFFF);
    drain();
  endtask

  // Random views, mostly small extents, with random indexes
  task automatic test_random_views();
    int count;
    for (int v = 0; v < 30; v++) begin
      set_view(rand_extent(), rand_extent(), rand_extent(), rand_extent(),
               rand_step(), rand_step(), rand_step(), rand_step());
      count = $urandom_range(30, 70);
      for (int i = 0; i < count; i++) send_index(rand_index());
      drain();
    end
  endtask

  initial begin
    foreach (dim_extent[k]) dim_extent[k] = 16'd1;
    foreach (dim_step[k]) dim_step[k] = '0;
    dim_step[0] = 32'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_directed_views();
    test_random_views();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
